FILE: hdl/pcc_pkg.sv
// Shared types, constants and codes for the polyline crossing checker.
`default_nettype none

package pcc_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 24;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int CROSS_BITS = 6;
  localparam int TOTAL_BITS = 16;

  // input commands
  localparam logic [1:0] CMD_FIRST_PT  = 2'd0;
  localparam logic [1:0] CMD_SECOND_PT = 2'd1;
  localparam logic [1:0] CMD_CLEAR     = 2'd2;

  // path kinds
  localparam logic [1:0] KIND_HUMAN = 2'd0;
  localparam logic [1:0] KIND_ROBOT = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;

  // job codes passed from the front to the back
  typedef logic [2:0] op_t;
  localparam op_t OP_NOP        = 3'd0;
  localparam op_t OP_CLEAR      = 3'd1;
  localparam op_t OP_STORE      = 3'd2;
  localparam op_t OP_STORE_NEW  = 3'd3;
  localparam op_t OP_SECOND_NEW = 3'd4;
  localparam op_t OP_SECOND_PT  = 3'd5;

  typedef struct packed {
    logic [1:0]                   cmd;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         first;
    logic [1:0]                   kind;
  } in_t;

  typedef struct packed {
    logic [CROSS_BITS-1:0] crossings;
    logic [TOTAL_BITS-1:0] total;
    logic                  segment_done;
    logic                  overflow;
  } out_t;

  typedef struct packed {
    op_t                          op;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [1:0]                   kind;
  } job_t;

  // one segment pair for the tester: stored segment a-b, new segment c-d
  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] dx;
    logic signed [COORD_BITS-1:0] dy;
    logic                         last;
  } seg_req_t;

  typedef struct packed {
    logic hit;
    logic last;
  } seg_res_t;

endpackage

`default_nettype wire

FILE: hdl/pcc_front.sv
// Front end: accept input transfers and turn them into jobs for the back end.
`default_nettype none

module pcc_front (
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pcc_pkg::in_t  in_data,
  output logic               push,
  output pcc_pkg::job_t      job,
  input  wire logic          full
);

  logic [1:0] kind_n;

  assign in_ready = !full;
  assign push     = in_valid && !full;

  // fold unused kind codes into other
  assign kind_n = (in_data.kind == pcc_pkg::KIND_HUMAN || in_data.kind == pcc_pkg::KIND_ROBOT)
                  ? in_data.kind : pcc_pkg::KIND_OTHER;

  always_comb begin
    job.x    = in_data.x;
    job.y    = in_data.y;
    job.kind = kind_n;
    case (in_data.cmd)
      pcc_pkg::CMD_FIRST_PT: begin
        job.op = in_data.first ? pcc_pkg::OP_STORE_NEW : pcc_pkg::OP_STORE;
      end
      pcc_pkg::CMD_SECOND_PT: begin
        job.op = in_data.first ? pcc_pkg::OP_SECOND_NEW : pcc_pkg::OP_SECOND_PT;
      end
      pcc_pkg::CMD_CLEAR: begin
        job.op = pcc_pkg::OP_CLEAR;
      end
      default: begin
        job.op = pcc_pkg::OP_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/pcc_queue.sv
// Two-entry job queue between the front and back ends.
`default_nettype none

module pcc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire pcc_pkg::job_t wr_job,
  output logic               full,
  output logic               q_valid,
  output pcc_pkg::job_t      rd_job,
  input  wire logic          pop
);

  pcc_pkg::job_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign rd_job  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pcc_seg_test.sv
// Pipelined four-orientation segment intersection tester, four stages.
`default_nettype none

module pcc_seg_test (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire pcc_pkg::seg_req_t req,
  output logic                   res_valid,
  output pcc_pkg::seg_res_t      res
);

  localparam int CB = pcc_pkg::COORD_BITS;
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;

  function automatic logic signed [DW-1:0] diff(input logic signed [CB-1:0] p,
                                                input logic signed [CB-1:0] q);
    diff = DW'(p) - DW'(q);
  endfunction

  function automatic logic in_box(input logic signed [CB-1:0] px,
                                  input logic signed [CB-1:0] py,
                                  input logic signed [CB-1:0] qx,
                                  input logic signed [CB-1:0] qy,
                                  input logic signed [CB-1:0] rx,
                                  input logic signed [CB-1:0] ry);
    logic okx;
    logic oky;
    okx = (qx >= px && qx <= rx) || (qx >= rx && qx <= px);
    oky = (qy >= py && qy <= ry) || (qy >= ry && qy <= py);
    in_box = okx && oky;
  endfunction

  // orientation code {zero, negative}; equal codes mean equal orientations
  function automatic logic [1:0] orient(input logic signed [PW-1:0] p,
                                        input logic signed [PW-1:0] q);
    logic signed [CW-1:0] v;
    v = CW'(p) - CW'(q);
    orient = {(v == '0), v[CW-1]};
  endfunction

  // stage 1: differences and box tests
  logic signed [DW-1:0] bxax, byay, cyay, cxax, dyay, dxax;
  logic signed [DW-1:0] aycy, dxcx, dycy, axcx, bycy, bxcx;
  logic [3:0] box1;
  logic       v1, last1;

  // stage 2: products
  logic signed [PW-1:0] p1a, p1b, p2a, p2b, p3a, p3b, p4a, p4b;
  logic [3:0] box2;
  logic       v2, last2;

  // stage 3: orientation codes
  logic [1:0] o1, o2, o3, o4;
  logic [3:0] box3;
  logic       v3, last3;

  always_ff @(posedge clk) begin
    bxax <= diff(req.bx, req.ax);
    byay <= diff(req.by, req.ay);
    cyay <= diff(req.cy, req.ay);
    cxax <= diff(req.cx, req.ax);
    dyay <= diff(req.dy, req.ay);
    dxax <= diff(req.dx, req.ax);
    aycy <= diff(req.ay, req.cy);
    dxcx <= diff(req.dx, req.cx);
    dycy <= diff(req.dy, req.cy);
    axcx <= diff(req.ax, req.cx);
    bycy <= diff(req.by, req.cy);
    bxcx <= diff(req.bx, req.cx);
    box1 <= {in_box(req.cx, req.cy, req.bx, req.by, req.dx, req.dy),
             in_box(req.cx, req.cy, req.ax, req.ay, req.dx, req.dy),
             in_box(req.ax, req.ay, req.dx, req.dy, req.bx, req.by),
             in_box(req.ax, req.ay, req.cx, req.cy, req.bx, req.by)};
    last1 <= req.last;

    p1a <= PW'(cyay) * PW'(bxax);
    p1b <= PW'(byay) * PW'(cxax);
    p2a <= PW'(dyay) * PW'(bxax);
    p2b <= PW'(byay) * PW'(dxax);
    p3a <= PW'(aycy) * PW'(dxcx);
    p3b <= PW'(dycy) * PW'(axcx);
    p4a <= PW'(bycy) * PW'(dxcx);
    p4b <= PW'(dycy) * PW'(bxcx);
    box2  <= box1;
    last2 <= last1;

    o1 <= orient(p1a, p1b);
    o2 <= orient(p2a, p2b);
    o3 <= orient(p3a, p3b);
    o4 <= orient(p4a, p4b);
    box3  <= box2;
    last3 <= last2;

    res.hit <= ((o1 != o2) && (o3 != o4)) ||
               (o1[1] && box3[0]) || (o2[1] && box3[1]) ||
               (o3[1] && box3[2]) || (o4[1] && box3[3]);
    res.last <= last3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1        <= req_valid;
      v2        <= v1;
      v3        <= v2;
      res_valid <= v3;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pcc_back.sv
// Back end: path state, point store, segment sweep sequencer and result register.
`default_nettype none

module pcc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_data,
  input  wire logic          q_valid,
  input  wire pcc_pkg::job_t job,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pcc_pkg::out_t      out_data
);

  localparam int CB = pcc_pkg::COORD_BITS;
  localparam int IB = pcc_pkg::IDX_BITS;
  localparam int NB = pcc_pkg::CNT_BITS;
  localparam int XB = pcc_pkg::CROSS_BITS;
  localparam int TB = pcc_pkg::TOTAL_BITS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]            state;
  logic [NB-1:0]         stored_count;
  logic [1:0]            first_kind;
  logic [1:0]            second_kind;
  logic signed [CB-1:0]  prev_x;
  logic signed [CB-1:0]  prev_y;
  logic                  have_prev;
  logic [TB-1:0]         total;
  logic [TB-1:0]         max_reports;
  logic [XB-1:0]         cross_cnt;

  // segment under test and sweep control
  logic signed [CB-1:0]  seg_cx, seg_cy, seg_dx, seg_dy;
  logic [NB-1:0]         rd_addr;
  logic                  rd_valid;
  logic                  rd_last;
  logic                  have_last;
  logic signed [CB-1:0]  last_x, last_y;

  // point store
  logic [2*CB-1:0]       mem [pcc_pkg::MAX_POINTS];
  logic [2*CB-1:0]       rdata;
  logic                  mem_we;
  logic [IB-1:0]         mem_wa;

  pcc_pkg::seg_req_t     req;
  logic                  req_valid;
  pcc_pkg::seg_res_t     res;
  logic                  res_valid;

  logic                  pair;
  logic [NB-1:0]         base_cnt;
  logic                  has_room;
  logic                  total_inc;
  logic [TB-1:0]         total_next;
  logic [XB-1:0]         cross_next;

  assign pop = (state == ST_IDLE) && q_valid && (!out_valid || out_ready);

  assign pair = (first_kind == pcc_pkg::KIND_HUMAN && second_kind == pcc_pkg::KIND_ROBOT) ||
                (first_kind == pcc_pkg::KIND_ROBOT && second_kind == pcc_pkg::KIND_HUMAN);

  assign base_cnt = (job.op == pcc_pkg::OP_STORE_NEW) ? '0 : stored_count;
  assign has_room = (base_cnt < NB'(pcc_pkg::MAX_POINTS));
  assign mem_we   = pop && (job.op == pcc_pkg::OP_STORE || job.op == pcc_pkg::OP_STORE_NEW)
                    && has_room;
  assign mem_wa   = base_cnt[IB-1:0];

  assign total_inc  = res_valid && res.hit && (total < max_reports);
  assign total_next = total + TB'(total_inc);
  assign cross_next = cross_cnt + XB'(res_valid && res.hit && (cross_cnt != '1));

  // hold store entry pairs: previous read data and current read data
  assign req_valid = rd_valid && have_last;
  assign req.ax    = last_x;
  assign req.ay    = last_y;
  assign req.bx    = rdata[2*CB-1:CB];
  assign req.by    = rdata[CB-1:0];
  assign req.cx    = seg_cx;
  assign req.cy    = seg_cy;
  assign req.dx    = seg_dx;
  assign req.dy    = seg_dy;
  assign req.last  = rd_last;

  pcc_seg_test u_test (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= {job.x, job.y};
    end
    rdata <= mem[rd_addr[IB-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      last_x <= rdata[2*CB-1:CB];
      last_y <= rdata[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_reports <= '1;
    end else if (cfg_we) begin
      max_reports <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      stored_count <= '0;
      first_kind   <= pcc_pkg::KIND_OTHER;
      second_kind  <= pcc_pkg::KIND_OTHER;
      prev_x       <= '0;
      prev_y       <= '0;
      have_prev    <= 1'b0;
      total        <= '0;
      cross_cnt    <= '0;
      rd_addr      <= '0;
      rd_valid     <= 1'b0;
      rd_last      <= 1'b0;
      have_last    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      rd_valid <= (state == ST_RUN);
      rd_last  <= (state == ST_RUN) && (rd_addr == stored_count - NB'(1));
      if (rd_valid) begin
        have_last <= 1'b1;
      end
      total     <= total_next;
      cross_cnt <= cross_next;

      case (state)
        ST_IDLE: begin
          if (pop) begin
            out_valid              <= 1'b1;
            out_data.crossings     <= '0;
            out_data.total         <= total;
            out_data.segment_done  <= 1'b0;
            out_data.overflow      <= 1'b0;
            case (job.op)
              pcc_pkg::OP_CLEAR: begin
                stored_count   <= '0;
                first_kind     <= pcc_pkg::KIND_OTHER;
                second_kind    <= pcc_pkg::KIND_OTHER;
                prev_x         <= '0;
                prev_y         <= '0;
                have_prev      <= 1'b0;
                total          <= '0;
                out_data.total <= '0;
              end
              pcc_pkg::OP_STORE, pcc_pkg::OP_STORE_NEW: begin
                if (job.op == pcc_pkg::OP_STORE_NEW) begin
                  first_kind <= job.kind;
                end
                if (has_room) begin
                  stored_count <= base_cnt + NB'(1);
                end else begin
                  stored_count      <= base_cnt;
                  out_data.overflow <= 1'b1;
                end
              end
              pcc_pkg::OP_SECOND_NEW: begin
                second_kind <= job.kind;
                prev_x      <= job.x;
                prev_y      <= job.y;
                have_prev   <= 1'b1;
              end
              pcc_pkg::OP_SECOND_PT: begin
                prev_x    <= job.x;
                prev_y    <= job.y;
                have_prev <= 1'b1;
                if (have_prev && pair) begin
                  out_data.segment_done <= 1'b1;
                  if (stored_count >= NB'(2)) begin
                    // sweep the store; the result is written when the last test returns
                    out_valid <= 1'b0;
                    state     <= ST_RUN;
                    seg_cx    <= prev_x;
                    seg_cy    <= prev_y;
                    seg_dx    <= job.x;
                    seg_dy    <= job.y;
                    rd_addr   <= '0;
                    have_last <= 1'b0;
                    cross_cnt <= '0;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          rd_addr <= rd_addr + NB'(1);
          if (rd_addr == stored_count - NB'(1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (res_valid && res.last) begin
            state                 <= ST_IDLE;
            out_valid             <= 1'b1;
            out_data.crossings    <= cross_next;
            out_data.total        <= total_next;
            out_data.segment_done <= 1'b1;
            out_data.overflow     <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/polyline_crossing_checker.sv
// Top level of the polyline crossing checker: front end, job queue and back end.
`default_nettype none

// Channel   | Direction | Signals                      | Transfer when
// ----------+-----------+------------------------------+---------------------------
// input     | in        | in_valid, in_ready, in_data  | in_valid && in_ready
// result    | out       | out_valid, out_ready, out_data | out_valid && out_ready
// config    | in        | cfg_we, cfg_data (max_reports) | cfg_we
//
// Every input transfer gives exactly one result transfer.
// Store, clear, new-path and no-op jobs are carried out as they are popped; a
// second-path point tested against a human/robot pair with two or more stored
// points holds the back end while the store read port sweeps one entry a cycle
// into one shared four-stage segment tester, until the last test returns.
// Reset (rst, synchronous) empties the queue and the store count; the store
// itself is not cleared. The two-entry queue keeps accepting transfers until
// it is full, while the back end sweeps or a result waits on out_ready.
module polyline_crossing_checker (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pcc_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pcc_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_data
);

  pcc_pkg::job_t front_job;
  pcc_pkg::job_t back_job;
  logic          push;
  logic          full;
  logic          q_valid;
  logic          pop;

  // classify each input transfer into a job
  pcc_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push),
    .job      (front_job),
    .full     (full)
  );

  // decouple acceptance from the back end's sweep
  pcc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_job  (front_job),
    .full    (full),
    .q_valid (q_valid),
    .rd_job  (back_job),
    .pop     (pop)
  );

  // carry out jobs against the path state and drive results
  pcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .job       (back_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: bench/tb_polyline_crossing_checker.sv
// Self-checking testbench for the polyline crossing checker.
`timescale 1ns / 100ps

module tb_polyline_crossing_checker;

  // Command and kind codes the package leaves unnamed
  localparam logic [1:0] CMD_IDLE   = 2'd3;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int COORD_MIN  = -(1 << (pcc_pkg::COORD_BITS - 1));
  localparam int COORD_MAX  = (1 << (pcc_pkg::COORD_BITS - 1)) - 1;
  // Cycles without any transfer before the run is declared hung
  localparam int HANG_LIMIT = 2000;
  // Quiet cycles after the last result
  localparam int TAIL_WAIT  = 100;

  logic           clk = 1'b0;
  logic           rst;
  logic           in_valid;
  logic           in_ready;
  pcc_pkg::in_t   in_data;
  logic           out_valid;
  logic           out_ready = 1'b0;
  pcc_pkg::out_t  out_data;
  logic           cfg_we;
  logic [15:0]    cfg_data;

  polyline_crossing_checker i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ------------------------------------------------------------------
  // Crossing predictor: a private copy of the first-path store, the
  // second-path tail point, both path kinds, the running total and the
  // limit register.
  // ------------------------------------------------------------------
  logic signed [pcc_pkg::COORD_BITS-1:0] path_x [pcc_pkg::MAX_POINTS];
  logic signed [pcc_pkg::COORD_BITS-1:0] path_y [pcc_pkg::MAX_POINTS];
  int                                    path_len;
  logic [1:0]                            path1_kind;
  logic [1:0]                            path2_kind;
  logic signed [pcc_pkg::COORD_BITS-1:0] tail_x;
  logic signed [pcc_pkg::COORD_BITS-1:0] tail_y;
  bit                                    tail_valid;
  int                                    crossing_total;
  logic [15:0]                           report_limit;

  // Results owed by the block, oldest first
  pcc_pkg::out_t due_results[$];

  // Run statistics and control
  int errors;
  int items_sent;
  int results_seen;
  int seg_tests;
  int hit_cnt;
  int drop_cnt;
  int limit_writes;
  int idle_cycles;
  bit gaps_on;
  bit stalls_on;
  int stall_left;

  // Sign of the cross product (b - a) x (c - a); exact integer math
  function automatic int turn(longint ax, longint ay, longint bx, longint by,
                              longint cx, longint cy);
    longint v;
    v = (cy - ay) * (bx - ax) - (by - ay) * (cx - ax);
    if (v == 0) return 0;
    return (v > 0) ? 1 : -1;
  endfunction

  // True when q lies inside the bounding box of p and r
  function automatic bit on_box(longint px, longint py, longint qx, longint qy,
                                longint rx, longint ry);
    longint lox, hix, loy, hiy;
    lox = (px < rx) ? px : rx;
    hix = (px < rx) ? rx : px;
    loy = (py < ry) ? py : ry;
    hiy = (py < ry) ? ry : py;
    return qx >= lox && qx <= hix && qy >= loy && qy <= hiy;
  endfunction

  // Four-orientation segment test, touching and collinear overlap included
  function automatic bit segments_meet(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy, longint dx, longint dy);
    int o1, o2, o3, o4;
    o1 = turn(ax, ay, bx, by, cx, cy);
    o2 = turn(ax, ay, bx, by, dx, dy);
    o3 = turn(cx, cy, dx, dy, ax, ay);
    o4 = turn(cx, cy, dx, dy, bx, by);
    if (o1 != o2 && o3 != o4) return 1'b1;
    if (o1 == 0 && on_box(ax, ay, cx, cy, bx, by)) return 1'b1;
    if (o2 == 0 && on_box(ax, ay, dx, dy, bx, by)) return 1'b1;
    if (o3 == 0 && on_box(cx, cy, ax, ay, dx, dy)) return 1'b1;
    if (o4 == 0 && on_box(cx, cy, bx, by, dx, dy)) return 1'b1;
    return 1'b0;
  endfunction

  // Clear everything except the limit register
  function automatic void reset_model();
    path_len       = 0;
    path1_kind     = pcc_pkg::KIND_OTHER;
    path2_kind     = pcc_pkg::KIND_OTHER;
    tail_x         = '0;
    tail_y         = '0;
    tail_valid     = 1'b0;
    crossing_total = 0;
  endfunction

  // Apply one accepted point to the predictor and return the owed result
  function automatic pcc_pkg::out_t advance_model(pcc_pkg::in_t pt);
    pcc_pkg::out_t res;
    int            hits;
    int            i;
    bit            pair;
    res  = '0;
    hits = 0;
    case (pt.cmd)
      pcc_pkg::CMD_FIRST_PT: begin
        // a first point empties the store before it is written
        if (pt.first) begin
          path_len   = 0;
          path1_kind = pt.kind;
        end
        if (path_len < pcc_pkg::MAX_POINTS) begin
          path_x[path_len] = pt.x;
          path_y[path_len] = pt.y;
          path_len++;
        end else begin
          res.overflow = 1'b1;
          drop_cnt++;
        end
      end
      pcc_pkg::CMD_SECOND_PT: begin
        if (pt.first) path2_kind = pt.kind;
        pair = (path1_kind == pcc_pkg::KIND_HUMAN && path2_kind == pcc_pkg::KIND_ROBOT) ||
               (path1_kind == pcc_pkg::KIND_ROBOT && path2_kind == pcc_pkg::KIND_HUMAN);
        // test only a real segment of a human/robot pairing
        if (!pt.first && tail_valid && pair) begin
          res.segment_done = 1'b1;
          seg_tests++;
          for (i = 0; i + 1 < path_len; i++) begin
            if (segments_meet(path_x[i], path_y[i], path_x[i+1], path_y[i+1],
                              tail_x, tail_y, pt.x, pt.y)) begin
              hits++;
              if (crossing_total < report_limit) crossing_total++;
            end
          end
        end
        tail_x     = pt.x;
        tail_y     = pt.y;
        tail_valid = 1'b1;
      end
      pcc_pkg::CMD_CLEAR: reset_model();
      default: ;
    endcase
    hit_cnt += hits;
    res.crossings = (hits > 63) ? 6'd63 : hits[5:0];
    res.total     = crossing_total[15:0];
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Result checker and watchdog. Check the result first: a result at an
  // edge can only belong to an item accepted at an earlier edge.
  // ------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    pcc_pkg::out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $error("result with nothing outstanding: %p", out_data);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (out_data.crossings !== want.crossings) begin
            $error("crossings: expected %0d, actual %0d", want.crossings,
                   out_data.crossings);
            errors++;
          end
          if (out_data.total !== want.total) begin
            $error("total: expected %0d, actual %0d", want.total, out_data.total);
            errors++;
          end
          if (out_data.segment_done !== want.segment_done) begin
            $error("segment_done: expected %0b, actual %0b", want.segment_done,
                   out_data.segment_done);
            errors++;
          end
          if (out_data.overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow,
                   out_data.overflow);
            errors++;
          end
        end
      end
      if (cfg_we) report_limit = cfg_data;
      if (in_valid && in_ready) due_results.push_back(advance_model(in_data));

      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, due_results.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Stall length: mostly short, now and then a long one
  function automatic int pick_stall();
    return ($urandom_range(0, 4) != 0) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Result side backpressure
  always @(posedge clk) begin
    if (!stalls_on) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 4) == 0) stall_left = pick_stall();
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  // Send one point; valid stays high on return so a following call can
  // chain without a bubble. Anything that lets time pass must drop it.
  task automatic send_point(logic [1:0] cmd, int x, int y, logic first,
                            logic [1:0] kind);
    pcc_pkg::in_t pt;
    int           gap;
    pt.cmd   = cmd;
    pt.x     = x[pcc_pkg::COORD_BITS-1:0];
    pt.y     = y[pcc_pkg::COORD_BITS-1:0];
    pt.first = first;
    pt.kind  = kind;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_stall() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pt;
    do @(posedge clk); while (!in_ready);
    if (cmd != CMD_IDLE) items_sent++;
  endtask

  // Hold off the sender until every owed result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(logic [15:0] value);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    limit_writes++;
  endtask

  // Coordinate draw; the scale sets how often points coincide or line up
  function automatic int rand_coord(int scale);
    case (scale)
      0: return $urandom_range(0, 8) - 4;
      1: return $urandom_range(0, 2000) - 1000;
      2: return $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return 0;
          3: return -1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Mostly human or robot, so that pairings are common
  function automatic logic [1:0] pick_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return pcc_pkg::KIND_HUMAN;
    if (r < 8) return pcc_pkg::KIND_ROBOT;
    return (r == 8) ? pcc_pkg::KIND_OTHER : KIND_SPARE;
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      5: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(2, 400));
    endcase
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Geometry, kind pairing, no-op, clear and coordinate extremes
  task automatic test_segment_cases();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_point(CMD_IDLE, 0, 0, 1'b0, pcc_pkg::KIND_HUMAN);       // no-op on fresh state
    send_point(pcc_pkg::CMD_SECOND_PT, 3, 3, 1'b0, pcc_pkg::KIND_HUMAN); // no predecessor
    send_point(pcc_pkg::CMD_SECOND_PT, 5, 5, 1'b0, pcc_pkg::KIND_ROBOT); // kinds still other
    // human zigzag through (0,0) (10,10) (20,0) (30,10)
    send_point(pcc_pkg::CMD_FIRST_PT, 0, 0, 1'b1, pcc_pkg::KIND_HUMAN);
    send_point(pcc_pkg::CMD_FIRST_PT, 10, 10, 1'b0, pcc_pkg::KIND_OTHER);
    send_point(pcc_pkg::CMD_FIRST_PT, 20, 0, 1'b0, pcc_pkg::KIND_OTHER);
    send_point(pcc_pkg::CMD_FIRST_PT, 30, 10, 1'b0, pcc_pkg::KIND_OTHER);
    // robot path: touches at vertices, then misses
    send_point(pcc_pkg::CMD_SECOND_PT, 0, 10, 1'b1, pcc_pkg::KIND_ROBOT);
    send_point(pcc_pkg::CMD_SECOND_PT, 40, 10, 1'b0, KIND_SPARE);
    send_point(pcc_pkg::CMD_SECOND_PT, 40, -5, 1'b0, pcc_pkg::KIND_HUMAN);
    // collinear overlap with the first stored segment, then a further overlap through (10,10)
    send_point(pcc_pkg::CMD_SECOND_PT, -5, -5, 1'b1, pcc_pkg::KIND_ROBOT);
    send_point(pcc_pkg::CMD_SECOND_PT, 5, 5, 1'b0, pcc_pkg::KIND_ROBOT);
    send_point(pcc_pkg::CMD_SECOND_PT, 15, 15, 1'b0, pcc_pkg::KIND_ROBOT);
    // same kind on both paths, then a spare kind: nothing tested
    send_point(pcc_pkg::CMD_SECOND_PT, 0, 5, 1'b1, pcc_pkg::KIND_HUMAN);
    send_point(pcc_pkg::CMD_SECOND_PT, 30, 5, 1'b0, pcc_pkg::KIND_HUMAN);
    send_point(pcc_pkg::CMD_SECOND_PT, 0, 5, 1'b1, KIND_SPARE);
    send_point(pcc_pkg::CMD_SECOND_PT, 30, 5, 1'b0, KIND_SPARE);
    // robot diagonal across the full coordinate range, human crossing it
    send_point(pcc_pkg::CMD_FIRST_PT, COORD_MIN, COORD_MIN, 1'b1, pcc_pkg::KIND_ROBOT);
    send_point(pcc_pkg::CMD_FIRST_PT, COORD_MAX, COORD_MAX, 1'b0, pcc_pkg::KIND_ROBOT);
    send_point(pcc_pkg::CMD_SECOND_PT, COORD_MIN, COORD_MAX, 1'b1, pcc_pkg::KIND_HUMAN);
    send_point(pcc_pkg::CMD_SECOND_PT, COORD_MAX, COORD_MIN, 1'b0, pcc_pkg::KIND_HUMAN);
    // clear with every other field bit set; the tail point goes with it
    send_point(pcc_pkg::CMD_CLEAR, -1, -1, 1'b1, KIND_SPARE);
    send_point(pcc_pkg::CMD_SECOND_PT, 1, 1, 1'b0, pcc_pkg::KIND_HUMAN);
  endtask

  // Saturation of the running total, a lowered limit, both extremes
  task automatic test_report_limit();
    set_limit(16'd1);
    // human square-ish path, robot horizontal segments cross two sides
    send_point(pcc_pkg::CMD_FIRST_PT, 0, 0, 1'b1, pcc_pkg::KIND_HUMAN);
    send_point(pcc_pkg::CMD_FIRST_PT, 0, 10, 1'b0, pcc_pkg::KIND_HUMAN);
    send_point(pcc_pkg::CMD_FIRST_PT, 10, 10, 1'b0, pcc_pkg::KIND_HUMAN);
    send_point(pcc_pkg::CMD_FIRST_PT, 10, 0, 1'b0, pcc_pkg::KIND_HUMAN);
    send_point(pcc_pkg::CMD_SECOND_PT, -5, 5, 1'b1, pcc_pkg::KIND_ROBOT);
    send_point(pcc_pkg::CMD_SECOND_PT, 15, 5, 1'b0, pcc_pkg::KIND_ROBOT);
    // limit lowered below the total: total must hold
    set_limit(16'd0);
    send_point(pcc_pkg::CMD_SECOND_PT, -5, 6, 1'b0, pcc_pkg::KIND_ROBOT);
    set_limit(16'hFFFF);
    send_point(pcc_pkg::CMD_SECOND_PT, 15, 7, 1'b0, pcc_pkg::KIND_ROBOT);
  endtask

  // Random phases: mostly well-formed path pairs, some broken sequences,
  // some noise, with limit writes and full drains between phases
  task automatic test_random_paths(int target);
    int         scale;
    int         shape;
    int         n;
    int         m;
    int         i;
    int         j;
    int         p;
    bit         zig;
    bit         broken;
    logic [1:0] k1;
    logic [1:0] k2;
    while (items_sent < target) begin
      case ($urandom_range(0, 5))
        0, 1: set_limit(pick_limit());
        2:    wait_drained();
        default: ;
      endcase
      gaps_on   = $urandom_range(0, 2) != 0;
      stalls_on = $urandom_range(0, 2) != 0;
      scale     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      shape     = $urandom_range(0, 19);
      if (shape == 0) begin
        // noise: any command, any fields
        n = $urandom_range(3, 12);
        for (i = 0; i < n; i++)
          send_point(2'($urandom_range(0, 3)), $urandom, $urandom,
                     1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
      end else if (shape == 1) begin
        send_point(pcc_pkg::CMD_CLEAR, $urandom, $urandom, 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)));
      end else begin
        // zigzag paths nearly or fully fill the store and give many crossings per segment
        zig    = $urandom_range(0, 7) == 0;
        broken = $urandom_range(0, 9) == 0;
        n      = zig ? $urandom_range(60, 70) : $urandom_range(1, 10);
        k1     = pick_kind();
        for (i = 0; i < n; i++) begin
          if (zig)
            send_point(pcc_pkg::CMD_FIRST_PT, i * 3 - 90, (i % 2) ? 5 : -5,
                       i == 0, (i == 0) ? k1 : 2'($urandom_range(0, 3)));
          else
            send_point(pcc_pkg::CMD_FIRST_PT, rand_coord(scale), rand_coord(scale),
                       i == 0 && !broken, (i == 0) ? k1 : 2'($urandom_range(0, 3)));
        end
        for (p = $urandom_range(1, 3); p > 0; p--) begin
          if ((k1 == pcc_pkg::KIND_HUMAN || k1 == pcc_pkg::KIND_ROBOT) &&
              $urandom_range(0, 4) != 0)
            k2 = (k1 == pcc_pkg::KIND_HUMAN) ? pcc_pkg::KIND_ROBOT : pcc_pkg::KIND_HUMAN;
          else
            k2 = pick_kind();
          broken = $urandom_range(0, 9) == 0;
          m      = $urandom_range(1, 8);
          for (j = 0; j < m; j++) begin
            if (zig)
              send_point(pcc_pkg::CMD_SECOND_PT, $urandom_range(0, 210) - 110,
                         $urandom_range(0, 8) - 4, j == 0 && !broken,
                         (j == 0) ? k2 : 2'($urandom_range(0, 3)));
            else
              send_point(pcc_pkg::CMD_SECOND_PT, rand_coord(scale), rand_coord(scale),
                         j == 0 && !broken, (j == 0) ? k2 : 2'($urandom_range(0, 3)));
          end
        end
        if ($urandom_range(0, 9) == 0) send_point(CMD_IDLE, $urandom, $urandom, 1'b1, 2'd3);
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    reset_model();
    report_limit = 16'hFFFF;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_segment_cases();
    test_report_limit();
    test_random_paths(850);

    // drain, then let any stray result show itself
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);

    $display("covered %0d points (%0d results), %0d segment tests, %0d crossings",
             items_sent, results_seen, seg_tests, hit_cnt);
    $display("covered %0d dropped points on a full store, %0d limit writes",
             drop_cnt, limit_writes);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
hdl/pcc_pkg.sv
hdl/pcc_front.sv
hdl/pcc_queue.sv
hdl/pcc_seg_test.sv
hdl/pcc_back.sv
hdl/polyline_crossing_checker.sv
bench/tb_polyline_crossing_checker.sv
